/* rtl/core/fp32_to_fp8_saturating_cast_defines.svh */
// ----------------------------------------------------------------------------
// fp32_to_fp8_saturating_cast_defines
// Assertion macros for the fp32 to fp8 cast block.
// ----------------------------------------------------------------------------
`ifndef FP32_TO_FP8_SATURATING_CAST_DEFINES_SVH
`define FP32_TO_FP8_SATURATING_CAST_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define F8C_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define F8C_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/f8c_pkg.sv */
// ----------------------------------------------------------------------------
// f8c_pkg
// Shared types, format tables and conversion function for the fp8 cast.
// ----------------------------------------------------------------------------
`default_nettype none

package f8c_pkg;

    typedef enum logic [1:0] {
        FMT_E4M3FN   = 2'd0,
        FMT_E4M3FNUZ = 2'd1,
        FMT_E5M2     = 2'd2,
        FMT_E5M2FNUZ = 2'd3
    } fp8_fmt_t;

    // Per-format constants decoded from the format register
    typedef struct packed {
        logic       mb3;     // 3 mantissa bits when set, else 2
        logic [7:0] sublo;
        logic [7:0] subtop;
        logic [7:0] ovf;
        logic [6:0] maxc;
        logic [7:0] nan;
        logic       fnuz;
    } fmt_info_t;

    function automatic fmt_info_t fmt_info(input fp8_fmt_t f);
        fmt_info_t r;
        case (f)
            FMT_E4M3FN:   r = '{1'b1, 8'd117, 8'd120, 8'd136, 7'h7E, 8'h7F, 1'b0};
            FMT_E4M3FNUZ: r = '{1'b1, 8'd116, 8'd119, 8'd135, 7'h7F, 8'h80, 1'b1};
            FMT_E5M2:     r = '{1'b0, 8'd110, 8'd112, 8'd143, 7'h7B, 8'h7E, 1'b0};
            FMT_E5M2FNUZ: r = '{1'b0, 8'd109, 8'd111, 8'd143, 7'h7F, 8'h80, 1'b1};
            default:      r = '{1'b1, 8'd117, 8'd120, 8'd136, 7'h7E, 8'h7F, 1'b0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/f8c_convert.sv */
// ----------------------------------------------------------------------------
// f8c_convert
// Combinational binary32 to fp8 conversion with round to nearest even.
// ----------------------------------------------------------------------------
`default_nettype none

module f8c_convert (
    input  wire logic [31:0]           single_bits,
    input  wire f8c_pkg::fp8_fmt_t     fmt,
    output logic [7:0]                 fp8_bits
);

    f8c_pkg::fmt_info_t fi;
    logic [7:0]  e;
    logic [22:0] m;
    logic [7:0]  sgn;
    logic [2:0]  mb;
    logic [7:0]  d;
    logic [22:0] mask;
    logic [7:0]  val;
    logic        rnd;
    logic [22:0] half;
    logic [7:0]  hi;

    always_comb begin
        fi   = f8c_pkg::fmt_info(fmt);
        e    = single_bits[30:23];
        m    = single_bits[22:0];
        sgn  = {single_bits[31], 7'd0};
        mb   = fi.mb3 ? 3'd3 : 3'd2;
        d    = 8'd0;
        mask = '0;
        val  = sgn;
        rnd  = 1'b0;
        half = '0;
        hi   = '0;
        if (single_bits[30:0] == 31'h7F800000) begin
            fp8_bits = sgn | {1'b0, fi.maxc};
        end else if (e == 8'hFF) begin
            fp8_bits = fi.fnuz ? 8'h80 : (sgn | fi.nan);
        end else if (e < fi.sublo) begin
            fp8_bits = fi.fnuz ? 8'h00 : sgn;
        end else if (e <= fi.subtop) begin
            // subnormal band
            d    = fi.subtop - e;
            mask = 23'd1 << (5'd23 - 5'(mb) + 5'(d));
            if (d < 8'(mb)) begin
                val = val | (8'd1 << (3'(mb) - 3'd1 - 3'(d)));
                val = val | 8'(m >> (5'd24 - 5'(mb) + 5'(d)));
            end else if (m != '0) begin
                val = val | 8'd1;
            end else if (fi.fnuz) begin
                val = 8'd0;
            end
            rnd = ((m & mask) != '0) &&
                  (val[0] || ((m & (mask - 23'd1)) != '0) ||
                   (((m & (mask << 1)) != '0) && ((m & (mask - 23'd1)) == '0)));
            fp8_bits = rnd ? (val + 8'd1) : val;
        end else if (e < fi.ovf) begin
            // normal band
            half = 23'd1 << (5'd22 - 5'(mb));
            hi   = (8'(e - fi.subtop) << mb) & 8'h7F;
            val  = val | hi | 8'(m >> (5'd23 - 5'(mb)));
            if (val[6:0] > fi.maxc)
                val = (val & 8'h80) | {1'b0, fi.maxc};
            if (((m & half) != '0) &&
                (((m & (half << 1)) != '0) || ((m & (half - 23'd1)) != '0))) begin
                if (val[6:0] < fi.maxc)
                    val = val + 8'd1;
            end
            fp8_bits = val;
        end else begin
            fp8_bits = sgn | {1'b0, fi.maxc};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/fp32_to_fp8_saturating_cast.sv */
// ----------------------------------------------------------------------------
// fp32_to_fp8_saturating_cast
// Streams binary32 values and returns fp8 codes in a selectable format.
// ----------------------------------------------------------------------------
// Channel   | Ports                             | Direction
// s_ (in)   | s_valid s_ready s_single_bits     | request in
// m_ (out)  | m_valid m_ready m_fp8_bits        | request out
// cfg       | cfg_we cfg_wdata                  | format register
//
// One request per cycle while the result register is not stalled; input register, then result register.
// The conversion is one pass of logic between the two registers.
// Reset (aresetn low, synchronous) clears valids and selects E4M3FN.
// A stalled result register stalls the input register; ready is the
// input slot being empty, or the result slot being free or draining.
`default_nettype none
`include "fp32_to_fp8_saturating_cast_defines.svh"

module fp32_to_fp8_saturating_cast (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_single_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_fp8_bits
);

    f8c_pkg::fp8_fmt_t fmt_reg;
    logic        in_valid_reg;
    logic [31:0] in_bits_reg;
    logic        out_valid_reg;
    logic [7:0]  out_bits_reg;
    logic [7:0]  conv_bits;
    logic        adv;

    // result stage advances when empty or being taken
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || adv;
    assign m_valid    = out_valid_reg;
    assign m_fp8_bits = out_bits_reg;

    // format register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= f8c_pkg::FMT_E4M3FN;
        end else if (cfg_we) begin
            fmt_reg <= f8c_pkg::fp8_fmt_t'(cfg_wdata);
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_bits_reg <= s_single_bits;
        end
    end

    f8c_convert u_convert (
        .single_bits (in_bits_reg),
        .fmt         (fmt_reg),
        .fp8_bits    (conv_bits)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid_reg;
        end
        if (adv && in_valid_reg) begin
            out_bits_reg <= conv_bits;
        end
    end

    `F8C_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        out_valid_reg && !m_ready, out_valid_reg, "result dropped while stalled")
    `F8C_ASSERT_IMP(a_ready_stall, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_ready, !s_ready, "accepted into full pipe")
    `F8C_ASSERT_NEXT(a_fill, aclk, aresetn,
        in_valid_reg && adv, out_valid_reg, "result lost on advance")

endmodule

`default_nettype wire
